// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted order block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sor_pkg.sv =====
// Types and constants of the sorted order reposition block.
package sor_pkg;

	localparam int ID_BITS     = 6;
	localparam int ID_COUNT    = 64;
	localparam int IN_KEY_BITS = 16;
	localparam int RES_BITS    = 6;
	localparam int STATUS_BITS = 2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANK,
		S_UP,
		S_DN,
		S_FIN
	} state_t;

endpackage

// ===== rtl/sorted_order_reposition.sv =====
// Top level: rank table by key; an append takes the next free rank and a move walks its entry
//   to its place. A move reads its rank in S_RANK, walks up in S_UP or down in S_DN, and ends
//   in S_FIN; appends and rejected requests go straight to S_FIN.
// One request at a time; the entry memory's single read port gives one neighbour compare and
//   swap per cycle, so a move makes at most MAX_ENTRIES - 1 swaps.
// Reset (arst_n, asynchronous): clears state, result valid, entry count and presence bits only.
`include "assert_macros.svh"

module sorted_order_reposition
	import sor_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int KEY_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // entity_id[5:0], new_key[21:6], zero[23:22]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // entity_id_res[5:0], final_rank[11:6],
	                              // swap_count[17:12], zero[23:18]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = ID_BITS + KEY_BITS;

	// Storage
	logic [EW-1:0] ent_mem [MAX_ENTRIES];
	logic [RW-1:0] rk_mem  [ID_COUNT];
	logic [ID_COUNT-1:0] present_q;
	logic [CW-1:0] count_q;

	state_t state_q, state_d;

	// Request under work
	logic [ID_BITS-1:0]        id_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [RW-1:0]             r_q, r_d;
	logic [RW-1:0]             n_q, n_d;
	status_t                   stat_q;
	logic                      wr_fin_q;

	// Memory ports
	logic                ent_rd_en, ent_wr_en;
	logic [RW-1:0]       ent_rd_addr, ent_wr_addr;
	logic [EW-1:0]       ent_wr_data, ent_rd_q;
	logic                rk_rd_en, rk_wr_en;
	logic [ID_BITS-1:0]  rk_wr_addr;
	logic [RW-1:0]       rk_wr_data, rk_rd_q;

	// Result register
	logic                m_tvalid_q;
	logic [ID_BITS-1:0]  res_id_q;
	logic [RES_BITS-1:0] res_rank_q, res_swaps_q;
	status_t             res_stat_q;

	logic                       take, out_load;
	logic [ID_BITS-1:0]         id_in;
	logic signed [KEY_BITS-1:0] key_in;
	logic                       kind_in;
	logic signed [KEY_BITS-1:0] nb_key;
	logic [ID_BITS-1:0]         nb_id;
	logic [CW-1:0]              r_ext, rr_ext;
	logic                       is_full;

	// Unpack the request and wrap the key to the table's key width
	assign id_in   = s_tdata[ID_BITS-1:0];
	assign key_in  = KEY_BITS'(signed'(s_tdata[ID_BITS +: IN_KEY_BITS]));
	assign kind_in = s_tuser[0];
	assign take    = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign is_full = (count_q >= CW'(MAX_ENTRIES));

	assign nb_id  = ent_rd_q[EW-1:KEY_BITS];
	assign nb_key = signed'(ent_rd_q[KEY_BITS-1:0]);
	assign r_ext  = CW'(r_q);
	assign rr_ext = CW'(rk_rd_q);

	// Next state, memory strobes and walk updates
	always_comb begin
		state_d     = state_q;
		r_d         = r_q;
		n_d         = n_q;
		ent_rd_en   = 1'b0;
		ent_rd_addr = RW'(r_ext + CW'(1));
		ent_wr_en   = 1'b0;
		ent_wr_addr = r_q;
		ent_wr_data = ent_rd_q;
		rk_rd_en    = 1'b0;
		rk_wr_en    = 1'b0;
		rk_wr_addr  = nb_id;
		rk_wr_data  = r_q;
		out_load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					n_d = '0;
					if (present_q[id_in]) begin
						rk_rd_en = 1'b1;
						state_d  = S_RANK;
					end else if (kind_in || is_full) begin
						r_d     = '0;
						state_d = S_FIN;
					end else begin
						r_d     = RW'(count_q);
						state_d = S_FIN;
					end
				end
			end
			S_RANK: begin
				r_d = rk_rd_q;
				if ((rr_ext + CW'(1)) < count_q) begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = RW'(rr_ext + CW'(1));
					state_d     = S_UP;
				end else if (rk_rd_q != '0) begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = rk_rd_q - RW'(1);
					state_d     = S_DN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_UP: begin
				if (key_q > nb_key) begin
					// Shift the upper neighbour down one rank
					ent_wr_en = 1'b1;
					rk_wr_en  = 1'b1;
					r_d       = RW'(r_ext + CW'(1));
					n_d       = n_q + RW'(1);
					if ((r_ext + CW'(2)) < count_q) begin
						ent_rd_en   = 1'b1;
						ent_rd_addr = RW'(r_ext + CW'(2));
					end else begin
						state_d = S_FIN;
					end
				end else if (n_q == '0 && r_q != '0) begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = r_q - RW'(1);
					state_d     = S_DN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN: begin
				if (key_q < nb_key) begin
					// Shift the lower neighbour up one rank
					ent_wr_en = 1'b1;
					rk_wr_en  = 1'b1;
					r_d       = r_q - RW'(1);
					n_d       = n_q + RW'(1);
					if (r_q > RW'(1)) begin
						ent_rd_en   = 1'b1;
						ent_rd_addr = r_q - RW'(2);
					end else begin
						state_d = S_FIN;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load    = 1'b1;
					ent_wr_en   = wr_fin_q;
					ent_wr_data = {id_q, key_q};
					rk_wr_en    = wr_fin_q;
					rk_wr_addr  = id_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Entry count and presence bits; an append commits them at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			count_q   <= '0;
		end else if (take && !present_q[id_in] && !kind_in && !is_full) begin
			present_q[id_in] <= 1'b1;
			count_q          <= count_q + CW'(1);
		end
	end

	// Hold the request and the walk position
	always_ff @(posedge clk) begin
		r_q <= r_d;
		n_q <= n_d;
		if (take) begin
			id_q  <= id_in;
			key_q <= key_in;
			if (present_q[id_in]) begin
				stat_q   <= ST_OK;
				wr_fin_q <= 1'b1;
			end else if (kind_in) begin
				stat_q   <= ST_UNKNOWN;
				wr_fin_q <= 1'b0;
			end else if (is_full) begin
				stat_q   <= ST_FULL;
				wr_fin_q <= 1'b0;
			end else begin
				stat_q   <= ST_OK;
				wr_fin_q <= 1'b1;
			end
		end
	end

	// Key and id by rank
	always_ff @(posedge clk) begin
		if (ent_wr_en) begin
			ent_mem[ent_wr_addr] <= ent_wr_data;
		end
		if (ent_rd_en) begin
			ent_rd_q <= ent_mem[ent_rd_addr];
		end
	end

	// Rank by id
	always_ff @(posedge clk) begin
		if (rk_wr_en) begin
			rk_mem[rk_wr_addr] <= rk_wr_data;
		end
		if (rk_rd_en) begin
			rk_rd_q <= rk_mem[id_in];
		end
	end

	// Result register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_id_q    <= id_q;
			res_rank_q  <= RES_BITS'(r_q);
			res_swaps_q <= RES_BITS'(n_q);
			res_stat_q  <= stat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, res_swaps_q, res_rank_q, res_id_q};
	assign m_tuser  = res_stat_q;

	// Checks
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(MAX_ENTRIES), "entry count over table size")
	`ASSERT_ALWAYS(a_present_count, clk, arst_n, $countones(present_q) == int'(count_q), "presence bits disagree with entry count")
	`ASSERT_IMPLIES(a_up_in_range, clk, arst_n, state_q == S_UP, (r_ext + CW'(1)) < count_q, "upward probe past last entry")
	`ASSERT_IMPLIES(a_dn_in_range, clk, arst_n, state_q == S_DN, r_q != '0, "downward probe below rank zero")
	`ASSERT_NEXT(a_append_grows, clk, arst_n, take && !present_q[id_in] && !kind_in && !is_full, count_q == $past(count_q) + CW'(1), "append did not grow the table")

endmodule

// ===== dv/sor_checker.sv =====
`timescale 1ns / 100ps
// Checker for the rank table: predicts each result from the accepted requests and compares.
module sor_checker
	import sor_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int KEY_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // entity_id[5:0], new_key[21:6], zero[23:22]
	input  logic [0:0]  s_tuser,  // kind[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // entity_id_res[5:0], final_rank[11:6],
	                              // swap_count[17:12], zero[23:18]
	input  logic [1:0]  m_tuser,  // status[1:0]
	output int          fail_count,
	output int          open_count,
	output int          result_total,
	output int          unknown_total,
	output int          deepest_walk
);

	typedef struct {
		logic [ID_BITS-1:0]  id;
		logic [RES_BITS-1:0] rank;
		logic [RES_BITS-1:0] swaps;
		status_t             status;
	} placement_t;

	// Shadow of the ordered table
	longint     key_at_rank [MAX_ENTRIES];
	int         id_at_rank  [MAX_ENTRIES];
	int         rank_of_id  [ID_COUNT];
	bit         present     [ID_COUNT];
	int         filled;
	placement_t awaited [$];
	int         mismatches;
	int         results;
	int         unknowns;
	int         longest;

	// Sign-extend the request key, then wrap it to the table's key width
	function automatic longint fold_key(logic [IN_KEY_BITS-1:0] raw);
		longint v;
		v = longint'($signed(raw));
		v = v & ((longint'(1) << KEY_BITS) - 1);
		if (v[KEY_BITS-1]) begin
			v = v - (longint'(1) << KEY_BITS);
		end
		return v;
	endfunction

	// Swap two neighbouring ranks and keep the id-to-rank map in step
	function automatic void exchange_ranks(int a, int b);
		longint k;
		int     i;
		k = key_at_rank[a];
		i = id_at_rank[a];
		key_at_rank[a] = key_at_rank[b];
		id_at_rank[a]  = id_at_rank[b];
		key_at_rank[b] = k;
		id_at_rank[b]  = i;
		rank_of_id[id_at_rank[a] % ID_COUNT] = a;
		rank_of_id[id_at_rank[b] % ID_COUNT] = b;
	endfunction

	// Apply one request to the shadow table and return the result it must give
	function automatic placement_t place_request(bit kind, logic [ID_BITS-1:0] id,
			logic [IN_KEY_BITS-1:0] raw_key);
		placement_t res;
		longint     key;
		int         r;
		int         n;
		key        = fold_key(raw_key);
		res.id     = id;
		res.rank   = '0;
		res.swaps  = '0;
		res.status = ST_OK;
		n          = 0;
		if (present[id]) begin
			// a known id moves, whether it came as an append or as a move
			r = rank_of_id[id];
			if (r < filled && r < MAX_ENTRIES) begin
				key_at_rank[r] = key;
				for (int g = 0; g < filled; g++) begin
					if (r + 1 < filled && key > key_at_rank[r + 1]) begin
						exchange_ranks(r, r + 1);
						r++;
						n++;
					end else if (r > 0 && key < key_at_rank[r - 1]) begin
						exchange_ranks(r, r - 1);
						r--;
						n++;
					end else begin
						break;
					end
				end
			end
			res.rank  = RES_BITS'(r);
			res.swaps = RES_BITS'(n);
		end else if (kind) begin
			res.status = ST_UNKNOWN;
		end else if (filled >= MAX_ENTRIES) begin
			res.status = ST_FULL;
		end else begin
			// plain append at the end, no sorting
			r               = filled;
			key_at_rank[r]  = key;
			id_at_rank[r]   = id;
			rank_of_id[id]  = r;
			present[id]     = 1'b1;
			filled++;
			res.rank = RES_BITS'(r);
		end
		return res;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Track requests and results on both channels
	always @(posedge clk or negedge arst_n) begin : watch
		placement_t seen;
		if (!arst_n) begin
			foreach (present[i]) present[i] = 1'b0;
			filled     = 0;
			mismatches = 0;
			results    = 0;
			unknowns   = 0;
			longest    = 0;
			awaited.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				awaited = {awaited, place_request(s_tuser[0], s_tdata[5:0], s_tdata[21:6])};
			end
			if (m_tvalid && m_tready) begin
				results++;
				if (awaited.size() == 0) begin
					$error("result for id %0d with no request waiting", m_tdata[5:0]);
					mismatches++;
				end else begin
					seen = awaited.pop_front();
					compare_field("entity_id_res", seen.id, m_tdata[5:0]);
					compare_field("final_rank", seen.rank, m_tdata[11:6]);
					compare_field("swap_count", seen.swaps, m_tdata[17:12]);
					compare_field("status", seen.status, m_tuser);
					if (seen.status == ST_UNKNOWN) unknowns++;
					if (seen.swaps > longest) longest = seen.swaps;
				end
			end
		end
		fail_count    <= mismatches;
		open_count    <= awaited.size();
		result_total  <= results;
		unknown_total <= unknowns;
		deepest_walk  <= longest;
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: drives requests into the rank table, paces both channels, gives the verdict.
module tb_top;
	import sor_pkg::*;

	localparam int ITEMS_PER_PHASE = 260;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 100;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	int fail_count;
	int open_count;
	int result_total;
	int unknown_total;
	int deepest_walk;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles  = 0;
	bit stall_sink    = 1'b0;
	bit stall_done    = 1'b0;
	bit id_used [ID_COUNT];

	always #5 clk = ~clk;

	sorted_order_reposition u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sor_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.open_count    (open_count),
		.result_total  (result_total),
		.unknown_total (unknown_total),
		.deepest_walk  (deepest_walk)
	);

	// Offer one request, idling first at the current rate, and hold it until taken
	task automatic send_req(input bit kind, input logic [ID_BITS-1:0] id,
			input logic [IN_KEY_BITS-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, key, id};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!kind) id_used[id] = 1'b1;
	endtask

	// Mostly appends of fresh ids and moves of known ones, with some stray ids
	task automatic send_random_req();
		bit                     kind;
		logic [ID_BITS-1:0]     id;
		logic [IN_KEY_BITS-1:0] key;
		int                     fresh [$];
		int                     known [$];
		int                     pick;
		foreach (id_used[i]) begin
			if (id_used[i]) known = {known, i};
			else fresh = {fresh, i};
		end
		kind = ($urandom_range(99) >= 35);
		id   = ID_BITS'($urandom_range(ID_COUNT - 1));
		if (!kind && fresh.size() > 0 && $urandom_range(99) < 80) begin
			id = ID_BITS'(fresh[$urandom_range(fresh.size() - 1)]);
		end else if (kind && known.size() > 0 && $urandom_range(99) < 85) begin
			id = ID_BITS'(known[$urandom_range(known.size() - 1)]);
		end
		pick = $urandom_range(99);
		if (pick < 40) begin
			key = IN_KEY_BITS'($urandom);
		end else if (pick < 70) begin
			// narrow band around zero gives plenty of equal keys
			key = IN_KEY_BITS'($urandom_range(16) - 8);
		end else if (pick < 80) begin
			key = $urandom_range(1) ? 16'h7fff : 16'h8000;
		end else begin
			key = IN_KEY_BITS'($urandom_range(255));
		end
		send_req(kind, id, key);
	endtask

	// Receiver pacing, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (stall_sink && !stall_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_done = 1'b1;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray move, key extremes, ties, full-length walks both ways
		send_req(1'b1, 6'd5, 16'h0000);
		send_req(1'b0, 6'd0, 16'h0000);
		send_req(1'b0, 6'd63, 16'h8000);
		send_req(1'b0, 6'd1, 16'h7fff);
		send_req(1'b0, 6'd2, 16'hffff);
		send_req(1'b0, 6'd3, 16'h0000);
		send_req(1'b0, 6'd0, 16'd100);
		send_req(1'b1, 6'd63, 16'h8000);
		send_req(1'b1, 6'd1, 16'h7fff);
		send_req(1'b1, 6'd3, 16'h0000);
		send_req(1'b1, 6'd2, 16'h7fff);
		send_req(1'b1, 6'd63, 16'h7fff);
		send_req(1'b1, 6'd10, 16'd5);
		send_req(1'b0, 6'd42, 16'h5555);
		send_req(1'b0, 6'd21, 16'haaaa);
		send_req(1'b0, 6'd10, 16'h0000);
		send_req(1'b1, 6'd0, 16'h8000);
		send_req(1'b1, 6'd42, 16'h8000);
		send_req(1'b1, 6'd21, 16'h7fff);
		send_req(1'b1, 6'd63, 16'h0000);

		// Random: slow receiver, then slow sender, then full rate after a hold-off
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 84 : 0;
			recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 13 : 0;
			if (ph == 2) stall_sink = 1'b1;
			repeat (ITEMS_PER_PHASE) send_random_req();
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then let the block settle
		do @(posedge clk); while (open_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (open_count != 0) $error("%0d results never arrived", open_count);

		$display("Covered %0d results: %0d for unknown ids, longest walk %0d swaps.",
			result_total, unknown_total, deepest_walk);
		$display("Pacing: slow receiver, slow sender, full rate with a long output hold-off.");
		if (fail_count == 0 && open_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sor_pkg.sv
rtl/sorted_order_reposition.sv
dv/sor_checker.sv
dv/tb_top.sv
